// ----- rtl/core/mvt_pkg.sv -----
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants of the 4x4 transform engine
// Element, product and sum types, function codes and pipeline control.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int ELEM_W        = 32;
  localparam int PROD_W        = 2 * ELEM_W;
  localparam int PAIR_W        = PROD_W + 1;
  localparam int SUM_W         = PROD_W + 2;
  localparam int DIM           = 4;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [DIM-1:0]          vec4_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam elem_t ELEM_MAX = elem_t'({1'b0, {(ELEM_W-1){1'b1}}});
  localparam elem_t ELEM_MIN = elem_t'({1'b1, {(ELEM_W-1){1'b0}}});

  localparam logic FUNC_WRITE_ROW = 1'b0;
  localparam logic FUNC_TRANSFORM = 1'b1;

  typedef struct packed {
    logic load_mul;
    logic load_pair;
    logic load_sat;
  } lane_ctrl_t;

endpackage

// ----- rtl/core/mvt_if.sv -----
// ----------------------------------------------------------------------------
// mvt_in_if / mvt_out_if: item channels of the transform engine
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface mvt_in_if import mvt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       func;
  logic [1:0] row_index;
  elem_t      elem0;
  elem_t      elem1;
  elem_t      elem2;
  elem_t      elem3;

  modport source (output valid, func, row_index, elem0, elem1, elem2, elem3,
                  input ready);
  modport sink   (input valid, func, row_index, elem0, elem1, elem2, elem3,
                  output ready);
endinterface

interface mvt_out_if import mvt_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t res0;
  elem_t res1;
  elem_t res2;
  elem_t res3;
  logic  overflow;

  modport source (output valid, res0, res1, res2, res3, overflow, input ready);
  modport sink   (input valid, res0, res1, res2, res3, overflow, output ready);
endinterface

// ----- rtl/core/mvt_lane.sv -----
// ----------------------------------------------------------------------------
// mvt_lane: one row of the transform
// Four registered multiplies, a registered pair add, then the final add,
// floor shift and saturation to 32 bits.
// ----------------------------------------------------------------------------
module mvt_lane import mvt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  lane_ctrl_t ctrl,
  input  vec4_t      row,
  input  vec4_t      vec,
  output elem_t      res,
  output logic       sat
);

  prod_t prod_r   [DIM];
  prod_t prod_nxt [DIM];
  pair_t pair_r   [2];
  pair_t pair_nxt [2];
  elem_t res_r, res_nxt;
  logic  sat_r, sat_nxt;

  sum_t                  sum;
  sum_t                  shifted;
  logic [SUM_W-ELEM_W:0] hi;

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      prod_nxt[j] = PROD_W'(row[j]) * PROD_W'(vec[j]);
    end
    pair_nxt[0] = PAIR_W'(prod_r[0]) + PAIR_W'(prod_r[1]);
    pair_nxt[1] = PAIR_W'(prod_r[2]) + PAIR_W'(prod_r[3]);
  end

  always_comb begin
    sum     = SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]);
    shifted = sum >>> FRAC_BITS;
    hi      = shifted[SUM_W-1:ELEM_W-1];
    sat_nxt = !((&hi) || !(|hi));
    if (!sat_nxt) begin
      res_nxt = shifted[ELEM_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      res_nxt = ELEM_MIN;
    end else begin
      res_nxt = ELEM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_mul) begin
      for (int j = 0; j < DIM; j++) begin
        prod_r[j] <= prod_nxt[j];
      end
    end
    if (ctrl.load_pair) begin
      pair_r[0] <= pair_nxt[0];
      pair_r[1] <= pair_nxt[1];
    end
    if (ctrl.load_sat) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

// ----- rtl/core/mvt_merge.sv -----
// ----------------------------------------------------------------------------
// mvt_merge: output register of the transform
// Gathers the four lane results into one item and folds the lane
// saturation flags into the overflow flag.
// ----------------------------------------------------------------------------
module mvt_merge import mvt_pkg::*; (
  input  logic           clk,
  input  logic           load,
  input  vec4_t          lane_res,
  input  logic [DIM-1:0] lane_sat,
  output vec4_t          res,
  output logic           overflow
);

  vec4_t res_r;
  logic  overflow_r, overflow_nxt;

  assign overflow_nxt = |lane_sat;

  always_ff @(posedge clk) begin
    if (load) begin
      res_r      <= lane_res;
      overflow_r <= overflow_nxt;
    end
  end

  assign res      = res_r;
  assign overflow = overflow_r;

endmodule

// ----- rtl/core/matrix_vector_transform_4x4.sv -----
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4: 4x4 Q16.16 matrix-vector transform engine
// Holds a row-major matrix; row-write items update it, transform items
// produce one saturated result item through four parallel row lanes.
//
//   channel   direction   payload
//   in_ch     sink        func, row_index, elem0..elem3
//   out_ch    source      res0..res3, overflow
//
// One item per cycle is accepted while the input is not stalled. A transform
// item's result is presented at the output after passing the multiply, pair
// add, final add with shift and saturation, and output registers. A row write
// takes effect at its acceptance edge and is seen by the next transform item.
// Reset clears the matrix and all valid bits. Each stage holds while the stage
// after it is full and stalled, so a waiting result stalls the input only once
// every stage is occupied.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4 import mvt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mvt_in_if.sink       in_ch,
  mvt_out_if.source    out_ch
);

  vec4_t matrix_r [DIM];
  vec4_t in_vec;

  logic v_mul_r, v_mul_nxt;
  logic v_pair_r, v_pair_nxt;
  logic v_sat_r, v_sat_nxt;
  logic v_out_r, v_out_nxt;

  logic rdy_out, rdy_sat, rdy_pair, rdy_mul;
  logic in_acc, load_row, load_out;

  lane_ctrl_t     ctrl;
  vec4_t          lane_res;
  logic [DIM-1:0] lane_sat;
  vec4_t          out_res;

  assign in_vec = {in_ch.elem3, in_ch.elem2, in_ch.elem1, in_ch.elem0};

  assign rdy_out  = !v_out_r  || out_ch.ready;
  assign rdy_sat  = !v_sat_r  || rdy_out;
  assign rdy_pair = !v_pair_r || rdy_sat;
  assign rdy_mul  = !v_mul_r  || rdy_pair;

  assign in_ch.ready = rdy_mul;
  assign in_acc      = in_ch.valid && rdy_mul;
  assign load_row    = in_acc && (in_ch.func == FUNC_WRITE_ROW);

  assign ctrl.load_mul  = in_acc && (in_ch.func == FUNC_TRANSFORM);
  assign ctrl.load_pair = v_mul_r && rdy_pair;
  assign ctrl.load_sat  = v_pair_r && rdy_sat;
  assign load_out       = v_sat_r && rdy_out;

  assign v_mul_nxt  = ctrl.load_mul  || (v_mul_r  && !rdy_pair);
  assign v_pair_nxt = ctrl.load_pair || (v_pair_r && !rdy_sat);
  assign v_sat_nxt  = ctrl.load_sat  || (v_sat_r  && !rdy_out);
  assign v_out_nxt  = load_out       || (v_out_r  && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_mul_r  <= 1'b0;
      v_pair_r <= 1'b0;
      v_sat_r  <= 1'b0;
      v_out_r  <= 1'b0;
      for (int i = 0; i < DIM; i++) begin
        matrix_r[i] <= '0;
      end
    end else begin
      v_mul_r  <= v_mul_nxt;
      v_pair_r <= v_pair_nxt;
      v_sat_r  <= v_sat_nxt;
      v_out_r  <= v_out_nxt;
      if (load_row) begin
        matrix_r[in_ch.row_index] <= in_vec;
      end
    end
  end

  for (genvar i = 0; i < DIM; i++) begin : g_lane
    mvt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .row  (matrix_r[i]),
      .vec  (in_vec),
      .res  (lane_res[i]),
      .sat  (lane_sat[i])
    );
  end

  mvt_merge u_merge (
    .clk      (clk),
    .load     (load_out),
    .lane_res (lane_res),
    .lane_sat (lane_sat),
    .res      (out_res),
    .overflow (out_ch.overflow)
  );

  assign out_ch.valid = v_out_r;
  assign out_ch.res0  = out_res[0];
  assign out_ch.res1  = out_res[1];
  assign out_ch.res2  = out_res[2];
  assign out_ch.res3  = out_res[3];

endmodule
